// ===== rtl/mpsf_pkg.sv =====
// Shared widths, request codes and limits of the phase-shift FIR unit.
package mpsf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int CHAN_W      = 3;
    localparam int CIDX_W      = 8;
    localparam int REQ_W       = 2;
    localparam int ROUND_SHIFT = 17;

    typedef logic [REQ_W-1:0] t_req_type;

    localparam t_req_type REQ_FILTER = 2'd0;
    localparam t_req_type REQ_LOAD   = 2'd1;
    localparam t_req_type REQ_CLEAR  = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

// ===== rtl/mpsf_ifs.sv =====
// Request, result and configuration channels of the phase-shift FIR unit.
interface mpsf_req_if;
    import mpsf_pkg::*;

    logic                       valid;
    logic                       ready;
    t_req_type                  req_type;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    modport source (output valid, req_type, channel, sample, coef_index, coef_value,
                    input ready);
    modport sink (input valid, req_type, channel, sample, coef_index, coef_value,
                  output ready);
endinterface

interface mpsf_res_if;
    import mpsf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;
    logic [CHAN_W-1:0]          out_channel;
    logic                       clipped;

    modport source (output valid, filtered, out_channel, clipped, input ready);
    modport sink (input valid, filtered, out_channel, clipped, output ready);
endinterface

interface mpsf_cfg_if;
    logic valid;
    logic ready;
    logic bypass;

    modport source (output valid, bypass, input ready);
    modport sink (input valid, bypass, output ready);
endinterface

// ===== rtl/multichannel_phase_shift_fir_unit.sv =====
// Multichannel 90-degree phase-shift FIR filter with one shared multiply-accumulate.
// A filter item writes its sample into the channel's circular history and then runs one
// shared 18x16 multiply-accumulate over all TAPS history entries against the loadable
// coefficient store, one entry per cycle; the block takes no new request until a filter
// result has moved to the output register, which follows from that single MAC and the
// one read port of each memory. Bypassed samples skip the MAC, and loads and clears end
// in the idle state. A clear resets the per-channel write positions and fill flags at once;
// history entries not yet written since a clear read as zero, so no sweep of the history
// memory is needed. The result sits in an output register, so the next item is accepted
// while a result still waits. Coefficients read as undefined until loaded.
module multichannel_phase_shift_fir_unit #(
    parameter int TAPS     = 256,
    parameter int CHANNELS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpsf_req_if.sink   i_req,
    mpsf_res_if.source o_res,
    mpsf_cfg_if.sink   i_cfg
);
    import mpsf_pkg::*;

    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHX_W  = (CH_W > CHAN_W) ? CH_W : CHAN_W;
    localparam int CIX_W  = (TAP_W > CIDX_W) ? TAP_W : CIDX_W;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + TAP_W;
    localparam int RND_W  = ACC_W + 1;
    localparam int Q_W    = RND_W - ROUND_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROUND,
        S_FINISH
    } t_state;

    t_state r_state;

    logic                       r_bypass;
    logic [TAP_W-1:0]           r_wp [CHANNELS];
    logic [CHANNELS-1:0]        r_full;

    logic signed [SAMPLE_W-1:0] r_hist [CHANNELS][TAPS];
    logic signed [COEF_W-1:0]   r_coef [TAPS];

    logic [CH_W-1:0]            r_ch;
    logic [CHAN_W-1:0]          r_ch_out;
    logic [TAP_W-1:0]           r_wp_cur;
    logic                       r_full_cur;
    logic [TAP_W-1:0]           r_k;
    logic [TAP_W-1:0]           r_p;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_hv;
    logic signed [SAMPLE_W-1:0] r_hq;
    logic signed [COEF_W-1:0]   r_cq;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_res_filt;
    logic                       r_res_clip;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_filt;
    logic [CHAN_W-1:0]          r_out_ch;
    logic                       r_out_clip;

    logic                       accept;
    logic [CHX_W-1:0]           req_ch;
    logic [CH_W-1:0]            req_chi;
    logic                       ch_ok;
    logic [CIX_W-1:0]           req_cidx;
    logic                       cidx_ok;
    logic                       is_filter;
    logic                       go_filter;
    logic                       go_bypass;
    logic                       go_load;
    logic                       go_clear;
    logic [TAP_W-1:0]           wp_sel;
    logic [TAP_W-1:0]           n_wp_adv;
    logic [TAP_W-1:0]           n_p;
    logic signed [SAMPLE_W-1:0] hist_op;
    logic signed [RND_W-1:0]    rnd_sum;
    logic signed [Q_W-1:0]      rnd_q;
    logic [Q_W-SAMPLE_W:0]      rnd_top;
    logic                       rnd_clip;
    logic signed [SAMPLE_W-1:0] rnd_val;

    assign accept    = i_req.valid && i_req.ready;
    assign req_ch    = CHX_W'(i_req.channel);
    assign req_chi   = req_ch[CH_W-1:0];
    assign ch_ok     = {1'b0, req_ch} < (CHX_W + 1)'(CHANNELS);
    assign req_cidx  = CIX_W'(i_req.coef_index);
    assign cidx_ok   = {1'b0, req_cidx} < (CIX_W + 1)'(TAPS);
    assign is_filter = accept && (i_req.req_type == REQ_FILTER) && ch_ok;
    assign go_filter = is_filter && !r_bypass;
    assign go_bypass = is_filter && r_bypass;
    assign go_load   = accept && (i_req.req_type == REQ_LOAD) && cidx_ok;
    assign go_clear  = accept && (i_req.req_type == REQ_CLEAR);

    assign wp_sel   = r_wp[req_chi];
    assign n_wp_adv = (wp_sel == TAP_W'(TAPS - 1)) ? '0 : wp_sel + 1'b1;
    assign n_p      = (r_p == TAP_W'(TAPS - 1)) ? '0 : r_p + 1'b1;

    assign hist_op  = r_hv ? r_hq : '0;

    assign rnd_sum  = RND_W'(r_acc) + (RND_W'(1) <<< (ROUND_SHIFT - 1));
    assign rnd_q    = rnd_sum[RND_W-1:ROUND_SHIFT];
    assign rnd_top  = rnd_q[Q_W-1:SAMPLE_W-1];
    assign rnd_clip = !((&rnd_top) || !(|rnd_top));
    assign rnd_val  = rnd_clip ? (rnd_q[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                               : rnd_q[SAMPLE_W-1:0];

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.filtered    = r_out_filt;
    assign o_res.out_channel = r_out_ch;
    assign o_res.clipped     = r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bypass    <= 1'b0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_bypass <= i_cfg.bypass;
            end
            if (r_out_valid && o_res.ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
            unique case (r_state)
                S_IDLE: begin
                    if (go_filter) begin
                        r_wp[req_chi] <= n_wp_adv;
                        if (wp_sel == TAP_W'(TAPS - 1)) begin
                            r_full[req_chi] <= 1'b1;
                        end
                        r_state <= S_RUN;
                    end else if (go_bypass) begin
                        r_state <= S_FINISH;
                    end else if (go_clear) begin
                        r_full <= '0;
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_wp[c] <= '0;
                        end
                    end
                end
                S_RUN: begin
                    if (r_k == TAP_W'(TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_filt  <= r_res_filt;
                        r_out_ch    <= r_ch_out;
                        r_out_clip  <= r_res_clip;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (go_filter) begin
            r_hist[req_chi][wp_sel] <= i_req.sample;
        end
        if (go_load) begin
            r_coef[req_cidx[TAP_W-1:0]] <= i_req.coef_value;
        end
        r_hq <= r_hist[r_ch][r_p];
        r_cq <= r_coef[r_k];
        r_hv <= r_full_cur || (r_p <= r_wp_cur);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_cq * hist_op;
        if (accept) begin
            r_ch       <= req_chi;
            r_ch_out   <= i_req.channel;
            r_wp_cur   <= wp_sel;
            r_full_cur <= r_full[req_chi];
            r_k        <= '0;
            r_p        <= n_wp_adv;
            r_acc      <= '0;
            r_res_filt <= i_req.sample;
            r_res_clip <= 1'b0;
        end else begin
            if (r_state == S_RUN) begin
                r_k <= r_k + 1'b1;
                r_p <= n_p;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_state == S_ROUND) begin
                r_res_filt <= rnd_val;
                r_res_clip <= rnd_clip;
            end
        end
    end

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.clipped) |->
            (o_res.filtered == SAMPLE_MAX || o_res.filtered == SAMPLE_MIN))
        else $error("clipped result not at a rail");

    a_mac_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("accumulator active outside computation");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go_clear |=> (r_full == '0))
        else $error("histories not empty after clear");

endmodule

// ===== tb/tb_multichannel_phase_shift_fir_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the multichannel phase-shift FIR unit with a bit-exact predictor.
module tb_multichannel_phase_shift_fir_unit;
    import mpsf_pkg::*;

    localparam int TAPS         = 256;
    localparam int CHANNELS     = 8;
    localparam real CLK_PERIOD  = 10.0;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE       = TAPS + 40;
    localparam int LONG_HOLD    = 2000;
    localparam int STALL_LIMIT  = 12000;
    localparam int MAX_REPORTS  = 10;
    localparam int TABLE_LOADS  = 8;
    localparam int PHASE_ITEMS  = 6;

    localparam t_req_type REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic [CHAN_W-1:0]          out_channel;
        logic                       clipped;
    } t_fir_out;

    logic clk;
    logic rst_n;

    mpsf_req_if req_if ();
    mpsf_res_if res_if ();
    mpsf_cfg_if cfg_if ();

    multichannel_phase_shift_fir_unit #(
        .TAPS     (TAPS),
        .CHANNELS (CHANNELS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    logic signed [SAMPLE_W-1:0] hist_mem [CHANNELS][TAPS];
    logic signed [COEF_W-1:0]   coef_mem [TAPS];
    logic [CIDX_W-1:0]          wr_pos [CHANNELS];
    logic                       bypass_q;

    t_fir_out filtered_q [$];

    int unsigned errors;
    int unsigned n_results;
    int unsigned n_loads;
    int unsigned n_clears;
    int unsigned n_ignored;
    int unsigned n_clipped;
    int unsigned idle_cycles;
    int unsigned coef_amp;
    bit          hold_off;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void log_failure(string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("[%0t] %s", $time, msg);
        end
    endfunction

    function automatic int unsigned pick_gap(bit en);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!en || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(50, 400);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(int unsigned amp);
        int v;
        v = int'($urandom_range(0, 2 * amp - 1)) - int'(amp);
        return v[COEF_W-1:0];
    endfunction

    function automatic void phase_shift_step(t_req_type rt, logic [CHAN_W-1:0] ch,
                                             logic signed [SAMPLE_W-1:0] smp,
                                             logic [CIDX_W-1:0] ci,
                                             logic signed [COEF_W-1:0] cv);
        t_fir_out           o;
        logic signed [63:0] acc;
        logic signed [63:0] r;
        int                 wp;
        case (rt)
            REQ_LOAD: begin
                coef_mem[ci] = cv;
                n_loads++;
            end
            REQ_CLEAR: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    wr_pos[c] = '0;
                    for (int t = 0; t < TAPS; t++) hist_mem[c][t] = '0;
                end
                n_clears++;
            end
            REQ_FILTER: begin
                if (bypass_q) begin
                    o = '{filtered: smp, out_channel: ch, clipped: 1'b0};
                end else begin
                    wp = int'(wr_pos[ch]);
                    hist_mem[ch][wp] = smp;
                    acc = '0;
                    for (int k = 0; k < TAPS; k++) begin
                        acc = acc + coef_mem[k] * hist_mem[ch][(wp + 1 + k) % TAPS];
                    end
                    wr_pos[ch] = CIDX_W'((wp + 1) % TAPS);
                    r = (acc + 64'sd65536) >>> ROUND_SHIFT;
                    o.out_channel = ch;
                    o.clipped = 1'b1;
                    if (r > 64'sd32767) begin
                        o.filtered = SAMPLE_MAX;
                    end else if (r < -64'sd32768) begin
                        o.filtered = SAMPLE_MIN;
                    end else begin
                        o.filtered = r[SAMPLE_W-1:0];
                        o.clipped = 1'b0;
                    end
                end
                if (o.clipped) n_clipped++;
                n_results++;
                filtered_q.push_back(o);
            end
            default: begin
                n_ignored++;
            end
        endcase
    endfunction

    task automatic send_item(t_req_type rt, logic [CHAN_W-1:0] ch,
                             logic signed [SAMPLE_W-1:0] smp, logic [CIDX_W-1:0] ci,
                             logic signed [COEF_W-1:0] cv, int unsigned gap);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= rt;
        req_if.channel    <= ch;
        req_if.sample     <= smp;
        req_if.coef_index <= ci;
        req_if.coef_value <= cv;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        phase_shift_step(rt, ch, smp, ci, cv);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp,
                               int unsigned gap);
        send_item(REQ_FILTER, ch, smp, CIDX_W'($urandom), COEF_W'($urandom), gap);
    endtask

    task automatic drain(int unsigned settle);
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_bypass(logic b);
        drain(SETTLE);
        cfg_if.valid  <= 1'b1;
        cfg_if.bypass <= b;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        bypass_q = b;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_table(int unsigned amp, bit odd_only, bit idle);
        logic signed [COEF_W-1:0] cv;
        logic [CIDX_W-1:0]        ci;
        for (int k = 0; k < TABLE_LOADS; k++) begin
            ci = CIDX_W'($urandom_range(0, TAPS - 1));
            cv = (odd_only && ci[0] == 1'b0) ? '0 : rand_coef(amp);
            send_item(REQ_LOAD, CHAN_W'($urandom), SAMPLE_W'($urandom), ci, cv,
                      pick_gap(idle));
        end
    endtask

    task automatic random_items(int unsigned n, bit idle);
        int unsigned r;
        for (int unsigned i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                send_sample(CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_sample(),
                            pick_gap(idle));
            end else if (r < 93) begin
                send_item(REQ_LOAD, CHAN_W'($urandom), SAMPLE_W'($urandom),
                          CIDX_W'($urandom), rand_coef(coef_amp), pick_gap(idle));
            end else if (r < 96) begin
                send_item(REQ_CLEAR, CHAN_W'($urandom), SAMPLE_W'($urandom),
                          CIDX_W'($urandom), COEF_W'($urandom), pick_gap(idle));
            end else begin
                send_item(REQ_UNUSED, CHAN_W'($urandom), SAMPLE_W'($urandom),
                          CIDX_W'($urandom), COEF_W'($urandom), pick_gap(idle));
            end
        end
    endtask

    task automatic test_bypass_passthrough();
        write_bypass(1'b1);
        send_sample(3'd0, '0, 0);
        send_sample(3'd7, SAMPLE_MAX, 1);
        send_sample(3'd3, SAMPLE_MIN, 0);
        send_item(REQ_CLEAR, '0, '0, '0, '0, 2);
        send_sample(3'd5, '1, 0);
        send_item(REQ_UNUSED, '1, '1, '1, '1, 0);
        send_sample(3'd6, 16'sd1, 0);
    endtask

    task automatic test_rounding_and_saturation();
        write_bypass(1'b0);
        for (int k = 0; k < TAPS; k++) begin
            send_item(REQ_LOAD, '0, '0, CIDX_W'(k),
                      (k == TAPS - 1) ? 18'sd65536 : 18'sd0, 0);
        end
        send_sample(3'd0, 16'sd1, 0);
        send_sample(3'd0, -16'sd1, 0);
        send_sample(3'd0, 16'sd3, 0);
        send_sample(3'd0, SAMPLE_MAX, 0);
        send_sample(3'd0, SAMPLE_MIN, 0);
        send_item(REQ_LOAD, '0, '0, CIDX_W'(TAPS - 1), 18'sh20000, 0);
        send_sample(3'd1, SAMPLE_MIN, 0);
        send_item(REQ_LOAD, '0, '0, CIDX_W'(TAPS - 2), 18'sh20000, 0);
        send_sample(3'd2, SAMPLE_MAX, 0);
        send_sample(3'd2, SAMPLE_MAX, 0);
        send_item(REQ_CLEAR, '1, '1, '1, '1, 0);
        send_sample(3'd2, 16'sd5, 0);
        send_item(REQ_UNUSED, '0, '0, '0, '0, 0);
        send_sample(3'd7, SAMPLE_MIN, 0);
    endtask

    task automatic test_random_phases();
        int unsigned amps [7] = '{1024, 8192, 131072, 512, 4096, 131072, 2048};
        for (int ph = 0; ph < 7; ph++) begin
            write_bypass(ph == 4);
            coef_amp = amps[ph];
            load_table(coef_amp, ph % 3 == 1, ph % 2 == 0);
            random_items(PHASE_ITEMS, ph != 3);
        end
    endtask

    task automatic test_output_backpressure();
        write_bypass(1'b0);
        coef_amp = 2048;
        hold_off = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_sample(CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_sample(), 0);
        end
        req_if.valid <= 1'b0;
        while (hold_off) @(posedge clk);
        random_items(10, 1'b1);
        write_bypass(1'b1);
        hold_off = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_sample(CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_sample(), 0);
        end
        req_if.valid <= 1'b0;
        while (hold_off) @(posedge clk);
    endtask

    task automatic test_sender_pause();
        write_bypass(1'b0);
        for (int i = 0; i < 4; i++) begin
            random_items(5, 1'b1);
            drain(0);
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_FILTER;
        req_if.channel = '0;
        req_if.sample = '0;
        req_if.coef_index = '0;
        req_if.coef_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.bypass = 1'b0;
        bypass_q = 1'b0;
        hold_off = 1'b0;
        coef_amp = 1024;
        errors = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            wr_pos[c] = '0;
            for (int t = 0; t < TAPS; t++) hist_mem[c][t] = '0;
        end
        for (int t = 0; t < TAPS; t++) coef_mem[t] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bypass_passthrough();
        test_rounding_and_saturation();
        test_random_phases();
        test_output_backpressure();
        test_sender_pause();
        drain(SETTLE);

        if (filtered_q.size() != 0) log_failure("results still outstanding at end of run");
        $display("Run covered %0d results (%0d clipped), %0d coefficient loads, %0d clears,",
                 n_results, n_clipped, n_loads, n_clears);
        $display("%0d ignored items, bypass on and off, output stalls and sender pauses.",
                 n_ignored);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        int unsigned n;
        res_if.ready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off = 1'b0;
            end else begin
                n = pick_gap(coef_amp != 512);
                if (n == 0) begin
                    res_if.ready <= 1'b1;
                    @(posedge clk);
                end else begin
                    res_if.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        t_fir_out e;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (filtered_q.size() == 0) begin
                log_failure($sformatf("unexpected result: filtered=%0d ch=%0d clipped=%0b",
                                      res_if.filtered, res_if.out_channel, res_if.clipped));
            end else begin
                e = filtered_q.pop_front();
                if (res_if.filtered !== e.filtered || res_if.out_channel !== e.out_channel
                        || res_if.clipped !== e.clipped) begin
                    log_failure($sformatf(
                        "mismatch: exp filtered=%0d ch=%0d clipped=%0b, got %0d %0d %0b",
                        e.filtered, e.out_channel, e.clipped,
                        res_if.filtered, res_if.out_channel, res_if.clipped));
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake", idle_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule
